>>> design/wsl_pkg.sv
// shared constants, types and register codes of the string wave solver
// no dependencies
package wsl_pkg;

  localparam int unsigned POINTS     = 64;
  localparam int unsigned IDX_W      = $clog2(POINTS);
  localparam int unsigned NP_W       = 7;
  localparam int unsigned DISP_W     = 24;
  localparam int unsigned K_W        = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_COURANT_SQ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS = 2'd1;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  localparam logic [K_W-1:0]  K_RESET  = 16'd26214;
  localparam logic [NP_W-1:0] NP_RESET = 7'd64;
  localparam logic [NP_W-1:0] NP_MIN   = 7'd3;
  localparam logic [NP_W-1:0] NP_MAX   = NP_W'(POINTS);

  typedef logic signed [DISP_W-1:0] disp_t;
  typedef logic [IDX_W-1:0]         idx_t;

  typedef struct packed {
    logic first;
    logic zero;
  } alu_ctl_t;

endpackage

>>> design/wsl_in_if.sv
// input channel of the string wave solver: load or step transactions
// depends on wsl_pkg
interface wsl_in_if;
  import wsl_pkg::*;

  logic  valid;
  logic  ready;
  logic  action;
  idx_t  point_index;
  disp_t sample_value;

  modport source (output valid, action, point_index, sample_value, input ready);
  modport sink   (input valid, action, point_index, sample_value, output ready);
endinterface

>>> design/wsl_out_if.sv
// result channel of the string wave solver: one transaction per row point
// depends on wsl_pkg
interface wsl_out_if;
  import wsl_pkg::*;

  logic  valid;
  logic  ready;
  idx_t  point_index_res;
  disp_t displacement;
  logic  last;

  modport source (output valid, point_index_res, displacement, last, input ready);
  modport sink   (input valid, point_index_res, displacement, last, output ready);
endinterface

>>> design/wsl_cfg_if.sv
// configuration write channel of the string wave solver
// depends on wsl_pkg
interface wsl_cfg_if;
  import wsl_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/wave_string_leapfrog_step.sv
// Leapfrog solver for a string with fixed ends. A load transaction writes one
// point of the current row and leaves the input ready. A step transaction
// emits the whole new row, points 0 to n-1 in order, and keeps the input busy
// until its last point is written back, longer if the result side stalls.
// Each point takes a row read, a pass through the shared multiplier and a
// round, saturate and write-back step, one point at a time. Row memories
// read as zero until written, through a valid flag per entry cleared by reset.
// depends on wsl_pkg, wsl_in_if, wsl_out_if, wsl_cfg_if, wsl_ram, wsl_alu
module wave_string_leapfrog_step (
  input  logic    clk_i,
  input  logic    rst_ni,
  wsl_in_if.sink  in_i,
  wsl_out_if.source out_o,
  wsl_cfg_if.sink cfg_i
);
  import wsl_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PRE  = 3'd1;
  localparam logic [2:0] S_LD0  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_RES  = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [K_W-1:0]  k_q;
  logic [NP_W-1:0] np_q;
  logic [NP_W-1:0] n_q;
  idx_t            i_q;
  logic            first_q;
  logic [POINTS-1:0] cur_vld_q, old_vld_q;
  logic            cur_rv_q, old_rv_q;
  disp_t           c_prev_q, c_cur_q, c_nxt_q;
  logic            out_vld_q;
  idx_t            out_idx_q;
  disp_t           out_disp_q;
  logic            out_last_q;

  logic     in_fire, load_fire, step_fire, cfg_fire;
  logic     is_last, advance;
  idx_t     cur_raddr, cur_waddr;
  logic     cur_we, old_we;
  disp_t    cur_wdata, cur_rdata, old_rdata, cur_rd, old_rd, res;
  logic [NP_W-1:0] n_clamp;
  alu_ctl_t ctl;

  assign in_fire   = in_i.valid && in_i.ready;
  assign load_fire = in_fire && (in_i.action == ACT_LOAD);
  assign step_fire = in_fire && (in_i.action == ACT_STEP);
  assign cfg_fire  = cfg_i.valid && cfg_i.ready;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign out_o.valid           = out_vld_q;
  assign out_o.point_index_res = out_idx_q;
  assign out_o.displacement    = out_disp_q;
  assign out_o.last            = out_last_q;

  assign n_clamp = (np_q < NP_MIN) ? NP_MIN : ((np_q > NP_MAX) ? NP_MAX : np_q);
  assign is_last = ({1'b0, i_q} == (n_q - NP_W'(1)));
  assign advance = (state_q == S_RES) && (!out_vld_q || out_o.ready);

  assign cur_raddr = (state_q == S_PRE) ? '0 : i_q + idx_t'(1);
  assign cur_rd    = cur_rv_q ? cur_rdata : '0;
  assign old_rd    = old_rv_q ? old_rdata : '0;

  assign cur_we    = load_fire || advance;
  assign cur_waddr = advance ? i_q : in_i.point_index;
  assign cur_wdata = advance ? res : in_i.sample_value;
  assign old_we    = advance;

  assign ctl.first = first_q;
  assign ctl.zero  = (i_q == '0) || is_last;

  wsl_ram #(.WIDTH(DISP_W), .DEPTH(POINTS)) u_cur_ram (
    .clk_i   (clk_i),
    .we_i    (cur_we),
    .waddr_i (cur_waddr),
    .wdata_i (cur_wdata),
    .raddr_i (cur_raddr),
    .rdata_o (cur_rdata)
  );

  wsl_ram #(.WIDTH(DISP_W), .DEPTH(POINTS)) u_old_ram (
    .clk_i   (clk_i),
    .we_i    (old_we),
    .waddr_i (i_q),
    .wdata_i (c_cur_q),
    .raddr_i (i_q),
    .rdata_o (old_rdata)
  );

  wsl_alu u_alu (
    .clk_i   (clk_i),
    .en_i    (state_q == S_MUL),
    .left_i  (c_prev_q),
    .mid_i   (c_cur_q),
    .right_i (cur_rd),
    .older_i (old_rd),
    .k_i     (k_q),
    .ctl_i   (ctl),
    .res_o   (res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (step_fire) begin
          state_d = S_PRE;
        end
      end
      S_PRE:  state_d = S_LD0;
      S_LD0:  state_d = S_RD;
      S_RD:   state_d = S_MUL;
      S_MUL:  state_d = S_RES;
      S_RES: begin
        if (advance) begin
          state_d = is_last ? S_IDLE : S_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      k_q        <= K_RESET;
      np_q       <= NP_RESET;
      n_q        <= NP_RESET;
      i_q        <= '0;
      first_q    <= 1'b1;
      cur_vld_q  <= '0;
      old_vld_q  <= '0;
      cur_rv_q   <= 1'b0;
      old_rv_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cur_rv_q <= cur_vld_q[cur_raddr];
      old_rv_q <= old_vld_q[i_q];
      if (cfg_fire && (cfg_i.index == REG_COURANT_SQ)) begin
        k_q <= cfg_i.data[K_W-1:0];
      end
      if (cfg_fire && (cfg_i.index == REG_NUM_POINTS)) begin
        np_q <= cfg_i.data[NP_W-1:0];
      end
      if (load_fire) begin
        cur_vld_q[in_i.point_index] <= 1'b1;
        first_q                     <= 1'b1;
      end
      if (step_fire) begin
        n_q <= n_clamp;
        i_q <= '0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (advance) begin
        cur_vld_q[i_q]       <= 1'b1;
        old_vld_q[i_q]       <= 1'b1;
        i_q                  <= i_q + idx_t'(1);
        if (is_last) begin
          first_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_LD0) begin
      c_cur_q <= cur_rd;
    end
    if (state_q == S_MUL) begin
      c_nxt_q <= cur_rd;
    end
    if (advance) begin
      c_prev_q   <= c_cur_q;
      c_cur_q    <= c_nxt_q;
      out_idx_q  <= i_q;
      out_disp_q <= res;
      out_last_q <= is_last;
    end
  end

endmodule

>>> design/wsl_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module wsl_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> design/wsl_alu.sv
// shared update unit: laplacian times courant factor, rounding, leapfrog sum
// and saturation; depends on wsl_pkg
module wsl_alu (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  wsl_pkg::disp_t         left_i,
  input  wsl_pkg::disp_t         mid_i,
  input  wsl_pkg::disp_t         right_i,
  input  wsl_pkg::disp_t         older_i,
  input  logic [wsl_pkg::K_W-1:0] k_i,
  input  wsl_pkg::alu_ctl_t      ctl_i,
  output wsl_pkg::disp_t         res_o
);
  import wsl_pkg::*;

  localparam int unsigned LAP_W  = DISP_W + 3;
  localparam int unsigned PROD_W = LAP_W + K_W + 1;
  localparam int unsigned TERM_W = PROD_W - K_W;
  localparam int unsigned SUM_W  = TERM_W + 2;

  logic signed [LAP_W-1:0]  lap;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  disp_t                    mid_q, older_q;
  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W-1:0] shifted;
  logic signed [TERM_W-1:0] term;
  logic signed [SUM_W-1:0]  sum;

  assign lap = LAP_W'(left_i) + LAP_W'(right_i) - (LAP_W'(mid_i) <<< 1);
  assign prod_d = PROD_W'(lap) * $signed({1'b0, k_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      mid_q   <= mid_i;
      older_q <= older_i;
    end
  end

  always_comb begin
    rnd     = ctl_i.first ? (PROD_W'(1) <<< K_W) : (PROD_W'(1) <<< (K_W - 1));
    shifted = ctl_i.first ? ((prod_q + rnd) >>> (K_W + 1)) : ((prod_q + rnd) >>> K_W);
    term    = shifted[TERM_W-1:0];
    if (ctl_i.first) begin
      sum = SUM_W'(mid_q) + SUM_W'(term);
    end else begin
      sum = (SUM_W'(mid_q) <<< 1) - SUM_W'(older_q) + SUM_W'(term);
    end
    if (ctl_i.zero) begin
      res_o = '0;
    end else if (sum > SUM_W'(disp_t'({1'b0, {(DISP_W-1){1'b1}}}))) begin
      res_o = {1'b0, {(DISP_W-1){1'b1}}};
    end else if (sum < SUM_W'(disp_t'({1'b1, {(DISP_W-1){1'b0}}}))) begin
      res_o = {1'b1, {(DISP_W-1){1'b0}}};
    end else begin
      res_o = sum[DISP_W-1:0];
    end
  end

endmodule

>>> design/wsl_checker.sv
// port-level checks of the string wave solver and their bind to the top level
// depends on wsl_pkg and wave_string_leapfrog_step
module wsl_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               in_action_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input wsl_pkg::idx_t      out_idx_i,
  input wsl_pkg::disp_t     out_disp_i,
  input logic               out_last_i
);
  import wsl_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_disp_i) && $stable(out_idx_i))
    else $error("result transaction changed while stalled");

  a_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_action_i == ACT_STEP) |=> !in_ready_i)
    else $error("input ready right after a step transaction");

  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_action_i == ACT_LOAD) |=> in_ready_i)
    else $error("load transaction did not finish in one cycle");

  a_first_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_idx_i == '0) |-> (out_disp_i == '0))
    else $error("first end point not zero");

  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_last_i |-> (out_disp_i == '0))
    else $error("last end point not zero");

endmodule

bind wave_string_leapfrog_step wsl_checker u_wsl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_action_i (in_i.action),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_idx_i   (out_o.point_index_res),
  .out_disp_i  (out_o.displacement),
  .out_last_i  (out_o.last)
);

>>> verif/tb.sv
// self-checking testbench of the string wave leapfrog solver
// predicts every emitted row point from its own copy of the string rows
// depends on wsl_pkg, wsl_in_if, wsl_out_if, wsl_cfg_if and the solver top level
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wsl_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 1000000;
  localparam int unsigned SQUEEZE_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 48;
  localparam longint DISP_HI = 64'sd8388607;
  localparam longint DISP_LO = -64'sd8388608;

  typedef struct {
    logic  action;
    idx_t  index;
    disp_t value;
  } string_cmd_t;

  typedef struct {
    idx_t  index;
    disp_t disp;
    logic  last;
  } row_point_t;

  logic clk_i = 1'b0;
  logic rst_n;

  wsl_in_if  in_ch ();
  wsl_out_if out_ch ();
  wsl_cfg_if cfg_ch ();

  wave_string_leapfrog_step dut (
    .clk_i  (clk_i),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  string_cmd_t string_cmds[$];
  row_point_t  row_points_due[$];

  logic [K_W-1:0]  courant_k = K_RESET;
  logic [NP_W-1:0] np_cfg = NP_RESET;
  disp_t string_now [POINTS] = '{default: '0};
  disp_t string_prev [POINTS] = '{default: '0};
  logic  first_pending = 1'b1;

  logic        steady = 1'b0;
  int unsigned squeeze_req = 0;
  int unsigned squeeze_done = 0;
  int unsigned hold_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned points_in_use(input logic [NP_W-1:0] np);
    if (np < NP_MIN) return int'(NP_MIN);
    if (np > NP_MAX) return int'(NP_MAX);
    return int'(np);
  endfunction

  // one leapfrog time step over the active points, queues the new row
  task automatic leapfrog_advance();
    int unsigned n;
    int          sh;
    longint      c;
    longint      lap;
    longint      term;
    longint      sum;
    disp_t       next_row [POINTS];
    row_point_t  pt;
    n = points_in_use(np_cfg);
    sh = first_pending ? 17 : 16;
    for (int i = 0; i < n; i++) begin
      if (i == 0 || i == n - 1) begin
        next_row[i] = '0;
      end else begin
        c = longint'(string_now[i]);
        lap = longint'(string_now[i-1]) + longint'(string_now[i+1]) - 2 * c;
        term = (lap * longint'(courant_k) + (longint'(1) << (sh - 1))) >>> sh;
        if (first_pending) sum = c + term;
        else sum = 2 * c - longint'(string_prev[i]) + term;
        if (sum > DISP_HI) sum = DISP_HI;
        else if (sum < DISP_LO) sum = DISP_LO;
        next_row[i] = disp_t'(sum);
      end
    end
    for (int i = 0; i < n; i++) begin
      string_prev[i] = string_now[i];
      string_now[i] = next_row[i];
      pt.index = idx_t'(i);
      pt.disp = next_row[i];
      pt.last = (i == n - 1);
      row_points_due.push_back(pt);
    end
    first_pending = 1'b0;
  endtask

  // input side
  always @(posedge clk_i) begin : drive
    string_cmd_t cmd;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (string_cmds.size() != 0 && (steady || $urandom_range(99) >= 29)) begin
        cmd = string_cmds.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.action <= cmd.action;
        in_ch.point_index <= cmd.index;
        in_ch.sample_value <= cmd.value;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side, with an occasional long hold-off
  always @(posedge clk_i) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (squeeze_done != squeeze_req) begin
        squeeze_done = squeeze_req;
        hold_cnt = SQUEEZE_CYCLES;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= 29);
      end
    end
  end

  // prediction on accepted transactions and comparison of results
  always @(posedge clk_i) begin : score
    row_point_t exp_pt;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.action == ACT_LOAD) begin
          string_now[in_ch.point_index] = in_ch.sample_value;
          first_pending = 1'b1;
        end else begin
          leapfrog_advance();
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (row_points_due.size() == 0) begin
          $error("unexpected row point: index %0d displacement %0d",
                 out_ch.point_index_res, out_ch.displacement);
          err_cnt++;
        end else begin
          exp_pt = row_points_due.pop_front();
          if (out_ch.point_index_res !== exp_pt.index) begin
            $error("point_index_res: expected %0d, actual %0d",
                   exp_pt.index, out_ch.point_index_res);
            err_cnt++;
          end
          if (out_ch.displacement !== exp_pt.disp) begin
            $error("displacement: expected %0d, actual %0d",
                   exp_pt.disp, out_ch.displacement);
            err_cnt++;
          end
          if (out_ch.last !== exp_pt.last) begin
            $error("last: expected %0b, actual %0b", exp_pt.last, out_ch.last);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic queue_load(input int unsigned idx, input disp_t val);
    string_cmd_t cmd;
    cmd.action = ACT_LOAD;
    cmd.index = idx_t'(idx);
    cmd.value = val;
    string_cmds.push_back(cmd);
  endtask

  task automatic queue_step();
    string_cmd_t cmd;
    cmd.action = ACT_STEP;
    cmd.index = idx_t'($urandom);
    cmd.value = disp_t'($urandom);
    string_cmds.push_back(cmd);
  endtask

  // called right after a rising edge, only while the solver is idle
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk_i); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    if (idx == REG_COURANT_SQ) courant_k = val[K_W-1:0];
    else if (idx == REG_NUM_POINTS) np_cfg = val[NP_W-1:0];
    @(posedge clk_i);
  endtask

  task automatic settle();
    while (string_cmds.size() != 0 || in_ch.valid || row_points_due.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic disp_t pick_disp();
    case ($urandom_range(5))
      0: return disp_t'(DISP_HI);
      1: return disp_t'(DISP_LO);
      2, 3: return disp_t'($urandom_range(2000) - 1000);
      default: return disp_t'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int unsigned n;
    int unsigned cnt;
    int unsigned steps;
    string_cmd_t cmd;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_LOAD;
    in_ch.point_index = '0;
    in_ch.sample_value = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_COURANT_SQ;
    cfg_ch.data = '0;
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // step straight out of reset, then extremes at both ends
    queue_step();
    queue_load(0, disp_t'(DISP_HI));
    queue_load(63, disp_t'(DISP_LO));
    queue_load(1, disp_t'(DISP_HI));
    queue_load(2, disp_t'(DISP_LO));
    queue_load(62, disp_t'(DISP_HI));
    queue_step();
    queue_step();
    queue_step();
    settle();

    // shortest string, largest factor, load beyond the active points
    set_reg(REG_COURANT_SQ, 16'hFFFF);
    set_reg(REG_NUM_POINTS, 16'd3);
    queue_load(0, disp_t'(DISP_HI));
    queue_load(1, disp_t'(DISP_LO));
    queue_load(2, disp_t'(DISP_HI));
    queue_load(40, disp_t'(-1));
    queue_step();
    queue_step();
    queue_step();
    settle();

    // point counts below and above the legal range
    set_reg(REG_COURANT_SQ, 16'd0);
    set_reg(REG_NUM_POINTS, 16'd0);
    queue_load(1, disp_t'(24'h123456));
    queue_step();
    settle();
    set_reg(REG_COURANT_SQ, 16'd1);
    set_reg(REG_NUM_POINTS, 16'd127);
    queue_load(30, disp_t'(DISP_LO));
    queue_step();
    queue_step();
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(3))
        0: set_reg(REG_COURANT_SQ, 16'd0);
        1: set_reg(REG_COURANT_SQ, 16'hFFFF);
        default: set_reg(REG_COURANT_SQ, 16'($urandom));
      endcase
      case ($urandom_range(9))
        7: set_reg(REG_NUM_POINTS, 16'd64);
        8: set_reg(REG_NUM_POINTS, 16'($urandom_range(127)));
        9: set_reg(REG_NUM_POINTS, 16'($urandom_range(63, 13)));
        default: set_reg(REG_NUM_POINTS, 16'($urandom_range(12, 3)));
      endcase
      n = points_in_use(np_cfg);
      steady = (ph == 2);
      cnt = 0;
      while (cnt < PHASE_ITEMS) begin
        if ($urandom_range(99) < 70) begin
          // well-formed: fill the row, then run a few time steps
          for (int i = 0; i < n; i++) queue_load(i, pick_disp());
          steps = $urandom_range(4, 1);
          for (int s = 0; s < steps; s++) queue_step();
          cnt += n + steps;
        end else begin
          cmd.action = 1'($urandom_range(1));
          cmd.index = idx_t'($urandom);
          cmd.value = pick_disp();
          string_cmds.push_back(cmd);
          cnt++;
        end
      end
      if (ph == 3) squeeze_req++;
      settle();
    end

    steady = 1'b0;
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/wsl_pkg.sv
design/wsl_in_if.sv
design/wsl_out_if.sv
design/wsl_cfg_if.sv
design/wsl_ram.sv
design/wsl_alu.sv
design/wave_string_leapfrog_step.sv
design/wsl_checker.sv
verif/tb.sv
